[sv/interval_or_coverage_checker_top_assert.svh]
// assertion macros for the interval or coverage checker
`ifndef INTERVAL_OR_COVERAGE_CHECKER_TOP_ASSERT_SVH
`define INTERVAL_OR_COVERAGE_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define IOC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ioc check failed");
`define IOC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ioc implication failed");
`define IOC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ioc next-cycle check failed");
`else
`define IOC_ASSERT(name, prop)
`define IOC_ASSERT_IMP(name, ante, cons)
`define IOC_ASSERT_NXT(name, ante, cons)
`endif

`endif

[sv/ioc_pkg.sv]
`default_nettype none

package ioc_pkg;

  localparam int MAX_BITS   = 10;
  localparam int VAL_W      = MAX_BITS;
  localparam int LIST_DEPTH = MAX_BITS + 1;
  localparam int MAP_SIZE   = 1 << MAX_BITS;
  localparam int MAP_AW     = MAX_BITS;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int MASK_W     = 10;
  localparam int KBITS_W    = 4;
  localparam int UNC_W      = 10;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [KBITS_W-1:0] MASK_BITS_RST = 4'd10;

  // register index taken from paddr above the byte offset
  localparam logic [ADDR_W-3:0] REG_MASK_BITS = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic clr;
    logic pop;
    logic push;
  } cell_ctl_t;

  typedef struct packed {
    logic              mark;
    logic              wipe;
    logic [MAP_AW-1:0] addr;
  } mark_req_t;

endpackage

`default_nettype wire

[sv/ioc_item_if.sv]
`default_nettype none

interface ioc_item_if;
  logic                        valid;
  logic                        ready;
  logic [ioc_pkg::MASK_W-1:0]  mask_value;
  logic                        last_entry;

  modport source (output valid, output mask_value, output last_entry, input ready);
  modport sink (input valid, input mask_value, input last_entry, output ready);
endinterface

`default_nettype wire

[sv/ioc_result_if.sv]
`default_nettype none

interface ioc_result_if;
  logic                       valid;
  logic                       ready;
  logic                       all_covered;
  logic [ioc_pkg::UNC_W-1:0]  uncovered_count;

  modport source (output valid, output all_covered, output uncovered_count, input ready);
  modport sink (input valid, input all_covered, input uncovered_count, output ready);
endinterface

`default_nettype wire

[sv/interval_or_coverage_checker_top.sv]
// interval or coverage checker
// item_i carries one mask per beat (mask_value, last_entry); result_o carries one
// beat (all_covered, uncovered_count) for each beat flagged last_entry.
// the list of distinct interval ors ending at the newest mask sits in a row of
// cells that shifts toward the head; each item walks that list once, one stored
// value per cycle, and marks each new value in a 1024 x 1 coverage memory.
// L being the stored list length (0 to 11), the walk over the cell row sets how
// long an item takes.
// for a last entry the result is loaded into the output register in the report
// state, after the walk over the list, the flush state and once that register
// is free; then the coverage memory is wiped one entry a cycle, all 1024
// entries, before the next beat is taken. after reset, and after each write of
// mask_bits over the apb port, the same wipe runs; mask_bits resets to 10.
// a stalled result beat holds in the output register; a next item is still
// taken meanwhile, and only a following result waits for the register to free.

`default_nettype none

`include "interval_or_coverage_checker_top_assert.svh"

module interval_or_coverage_checker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ioc_pkg::ADDR_W-1:0]    paddr,
  input  logic [ioc_pkg::DATA_W-1:0]    pwdata,
  output logic [ioc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  ioc_item_if.sink                      item_i,
  ioc_result_if.source                  result_o
);

  localparam int LD = ioc_pkg::LIST_DEPTH;

  ioc_pkg::state_e                  state_q, state_d;
  logic [ioc_pkg::KBITS_W-1:0]      mask_bits_q;
  logic [ioc_pkg::VAL_W-1:0]        lr_q, lr_d;
  logic [ioc_pkg::VAL_W-1:0]        x_q, x_d;
  logic [ioc_pkg::CNT_W-1:0]        n_q, n_d;
  logic [ioc_pkg::CNT_W-1:0]        pops_q, pops_d;
  logic [ioc_pkg::CNT_W-1:0]        len_q, len_d;
  logic                             last_q, last_d;
  logic [ioc_pkg::MAP_AW-1:0]       wipe_q, wipe_d;
  logic                             out_vld_q, out_vld_d;
  logic                             out_cov_q, out_cov_d;
  logic [ioc_pkg::UNC_W-1:0]        out_unc_q, out_unc_d;

  logic                             cfg_wr;
  logic                             item_acc;
  logic [ioc_pkg::KBITS_W-1:0]      kb;
  logic [ioc_pkg::VAL_W:0]          kmask_wide;
  logic [ioc_pkg::VAL_W-1:0]        kmask;
  logic [ioc_pkg::VAL_W-1:0]        xm;
  logic [ioc_pkg::VAL_W-1:0]        scan_v;
  logic [ioc_pkg::UNC_W-1:0]        count;
  logic [ioc_pkg::UNC_W-1:0]        unc;

  ioc_pkg::cell_ctl_t               cell_ctl;
  logic [ioc_pkg::VAL_W-1:0]        push_val;
  ioc_pkg::mark_req_t               mreq;
  logic [LD-1:0]                    cell_vld;
  logic [ioc_pkg::VAL_W-1:0]        cell_val [LD];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite &
                  (paddr[ioc_pkg::ADDR_W-1:2] == ioc_pkg::REG_MASK_BITS);
  assign prdata = (paddr[ioc_pkg::ADDR_W-1:2] == ioc_pkg::REG_MASK_BITS) ?
                  {{(ioc_pkg::DATA_W - ioc_pkg::KBITS_W){1'b0}}, mask_bits_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_bits_q <= ioc_pkg::MASK_BITS_RST;
    end else if (cfg_wr) begin
      mask_bits_q <= pwdata[ioc_pkg::KBITS_W-1:0];
    end
  end

  // effective bit count saturates at the maximum width
  assign kb = (mask_bits_q > ioc_pkg::KBITS_W'(ioc_pkg::MAX_BITS)) ?
              ioc_pkg::KBITS_W'(ioc_pkg::MAX_BITS) : mask_bits_q;
  assign kmask_wide = ({{ioc_pkg::VAL_W{1'b0}}, 1'b1} << kb) - 1'b1;
  assign kmask      = kmask_wide[ioc_pkg::VAL_W-1:0];
  assign xm         = item_i.mask_value[ioc_pkg::VAL_W-1:0] & kmask;
  assign unc        = (kmask > count) ? (kmask - count) : '0;

  assign item_i.ready = (state_q == ioc_pkg::ST_IDLE);
  assign item_acc     = item_i.valid & item_i.ready;
  assign scan_v       = cell_val[0] | x_q;

  assign result_o.valid           = out_vld_q;
  assign result_o.all_covered     = out_cov_q;
  assign result_o.uncovered_count = out_unc_q;

  always_comb begin
    state_d   = state_q;
    lr_d      = lr_q;
    x_d       = x_q;
    n_d       = n_q;
    pops_d    = pops_q;
    len_d     = len_q;
    last_d    = last_q;
    wipe_d    = wipe_q;
    out_vld_d = out_vld_q & ~result_o.ready;
    out_cov_d = out_cov_q;
    out_unc_d = out_unc_q;
    cell_ctl  = '0;
    push_val  = lr_q;
    mreq      = '0;
    mreq.addr = lr_q;

    case (state_q)
      ioc_pkg::ST_CLEAR: begin
        mreq.wipe = 1'b1;
        mreq.addr = wipe_q;
        wipe_d    = wipe_q + 1'b1;
        if (wipe_q == '1) begin
          state_d = ioc_pkg::ST_IDLE;
        end
      end
      ioc_pkg::ST_IDLE: begin
        if (item_acc) begin
          x_d       = xm;
          lr_d      = xm;
          n_d       = ioc_pkg::CNT_W'(1);
          pops_d    = len_q;
          last_d    = item_i.last_entry;
          mreq.mark = 1'b1;
          mreq.addr = xm;
          state_d   = (len_q == '0) ? ioc_pkg::ST_FLUSH : ioc_pkg::ST_SCAN;
        end
      end
      ioc_pkg::ST_SCAN: begin
        // the pending value goes into the row only once a different one follows
        cell_ctl.pop = 1'b1;
        if ((scan_v != lr_q) && (n_q < ioc_pkg::CNT_W'(LD))) begin
          cell_ctl.push = 1'b1;
          lr_d          = scan_v;
          n_d           = n_q + 1'b1;
          mreq.mark     = 1'b1;
          mreq.addr     = scan_v;
        end
        pops_d = pops_q - 1'b1;
        if (pops_q == ioc_pkg::CNT_W'(1)) begin
          state_d = ioc_pkg::ST_FLUSH;
        end
      end
      ioc_pkg::ST_FLUSH: begin
        cell_ctl.push = 1'b1;
        len_d         = n_q;
        state_d       = last_q ? ioc_pkg::ST_REPORT : ioc_pkg::ST_IDLE;
      end
      ioc_pkg::ST_REPORT: begin
        if (!out_vld_q || result_o.ready) begin
          out_vld_d    = 1'b1;
          out_cov_d    = (unc == '0);
          out_unc_d    = unc;
          cell_ctl.clr = 1'b1;
          len_d        = '0;
          wipe_d       = '0;
          state_d      = ioc_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_d = ioc_pkg::ST_CLEAR;
      end
    endcase

    // a new bit count starts a fresh sequence
    if (cfg_wr) begin
      cell_ctl.clr = 1'b1;
      len_d        = '0;
      wipe_d       = '0;
      state_d      = ioc_pkg::ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ioc_pkg::ST_CLEAR;
      len_q     <= '0;
      pops_q    <= '0;
      n_q       <= '0;
      last_q    <= 1'b0;
      wipe_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      pops_q    <= pops_d;
      n_q       <= n_d;
      last_q    <= last_d;
      wipe_q    <= wipe_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q      <= lr_d;
    x_q       <= x_d;
    out_cov_q <= out_cov_d;
    out_unc_q <= out_unc_d;
  end

  for (genvar j = 0; j < LD; j++) begin : g_cell
    logic                      prev_vld;
    logic                      next_vld;
    logic [ioc_pkg::VAL_W-1:0] next_val;

    if (j == 0) begin : g_head
      assign prev_vld = 1'b1;
    end else begin : g_body
      assign prev_vld = cell_vld[j-1];
    end

    if (j == LD - 1) begin : g_tail
      assign next_vld = 1'b0;
      assign next_val = '0;
    end else begin : g_link
      assign next_vld = cell_vld[j+1];
      assign next_val = cell_val[j+1];
    end

    ioc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl),
      .push_val_i (push_val),
      .prev_vld_i (prev_vld),
      .next_vld_i (next_vld),
      .next_val_i (next_val),
      .vld_o      (cell_vld[j]),
      .val_o      (cell_val[j])
    );
  end

  ioc_mark u_mark (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .count_o (count)
  );

  `IOC_ASSERT_IMP(a_idle_len_match, state_q == ioc_pkg::ST_IDLE, $countones(cell_vld) == len_q)
  `IOC_ASSERT_IMP(a_scan_head_vld, state_q == ioc_pkg::ST_SCAN, cell_vld[0])
  `IOC_ASSERT(a_len_bound, len_q <= ioc_pkg::CNT_W'(LD))
  `IOC_ASSERT_NXT(a_report_to_clear,
                  state_q == ioc_pkg::ST_REPORT && !cfg_wr && (!out_vld_q || result_o.ready),
                  out_vld_q && state_q == ioc_pkg::ST_CLEAR)

endmodule

`default_nettype wire

[sv/ioc_cell.sv]
`default_nettype none

module ioc_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ioc_pkg::cell_ctl_t        ctl_i,
  input  logic [ioc_pkg::VAL_W-1:0] push_val_i,
  input  logic                      prev_vld_i,
  input  logic                      next_vld_i,
  input  logic [ioc_pkg::VAL_W-1:0] next_val_i,
  output logic                      vld_o,
  output logic [ioc_pkg::VAL_W-1:0] val_o
);

  logic                      vld_q, vld_d;
  logic [ioc_pkg::VAL_W-1:0] val_q, val_d;
  logic                      self_after;
  logic                      prev_after;
  logic                      take;

  always_comb begin
    // occupancy of this cell and its left neighbor once the pop shift is done
    self_after = ctl_i.pop ? next_vld_i : vld_q;
    prev_after = ctl_i.pop ? vld_q : prev_vld_i;
    take       = ctl_i.push & ~self_after & prev_after;
    vld_d      = self_after;
    val_d      = ctl_i.pop ? next_val_i : val_q;
    if (take) begin
      vld_d = 1'b1;
      val_d = push_val_i;
    end
    if (ctl_i.clr) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign vld_o = vld_q;
  assign val_o = val_q;

endmodule

`default_nettype wire

[sv/ioc_mark.sv]
`default_nettype none

module ioc_mark (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ioc_pkg::mark_req_t         req_i,
  output logic [ioc_pkg::UNC_W-1:0]  count_o
);

  logic                       mem [ioc_pkg::MAP_SIZE];
  logic                       rd_q;
  logic                       s1_vld_q;
  logic [ioc_pkg::MAP_AW-1:0] s1_addr_q;
  logic                       fwd_q, fwd_d;
  logic [ioc_pkg::UNC_W-1:0]  count_q, count_d;
  logic                       fresh;
  logic                       wr_en;
  logic [ioc_pkg::MAP_AW-1:0] wr_addr;
  logic                       wr_data;

  always_comb begin
    // a read that races the write of the same entry sees it through fwd_q
    fresh   = s1_vld_q & ~(rd_q | fwd_q);
    fwd_d   = req_i.mark & s1_vld_q & (req_i.addr == s1_addr_q);
    wr_en   = req_i.wipe | fresh;
    wr_addr = req_i.wipe ? req_i.addr : s1_addr_q;
    wr_data = ~req_i.wipe;
    count_d = count_q;
    if (req_i.wipe) begin
      count_d = '0;
    end else if (fresh && (s1_addr_q != '0)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      count_q  <= '0;
    end else begin
      s1_vld_q <= req_i.mark & ~req_i.wipe;
      fwd_q    <= fwd_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= req_i.addr;
  end

  assign count_o = count_q;

endmodule

`default_nettype wire
